// ----- hw/rtl/tcw_pkg.sv -----
// ============================================================================
// Text console character writer: shared package
// Screen geometry, cell codes, request codes, payload types, and the command
// and status bundles that join the controller and the datapath.
// ============================================================================
package tcw_pkg;

  // Screen geometry. The last row is reserved and never written by text.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(CELLS);

  // Sweep landmarks in the screen store.
  localparam logic [ADDR_W-1:0] STORE_LAST    = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] TEXT_LAST     = ADDR_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [ADDR_W-1:0] COPY_FIRST    = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] ROWFILL_FIRST = ADDR_W'((ROWS - 2) * COLUMNS);
  localparam logic [ADDR_W-1:0] COLUMNS_A     = ADDR_W'(COLUMNS);

  localparam logic [4:0] ROW_TEXT_LAST = 5'(ROWS - 2);
  localparam logic [6:0] COL_LAST      = 7'(COLUMNS - 1);

  // Cell contents.
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] COLOR_RESET  = 8'd7;

  // Request codes.
  localparam logic [2:0] REQ_PUT   = 3'd0;
  localparam logic [2:0] REQ_BREAK = 3'd1;
  localparam logic [2:0] REQ_SOFT  = 3'd2;
  localparam logic [2:0] REQ_CLEAR = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        break_pending;
    logic [15:0] cell_data;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_COPY,
    ST_DRAIN,
    ST_ROWFILL,
    ST_CLEAR,
    ST_READ,
    ST_POST,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_req;
    logic sweep_clr;
    logic sweep_copy;
    logic sweep_row;
    logic copy_step;
    logic fill_step;
    logic fill_init;
    logic line_adv;
    logic cursor_home;
    logic char_write;
    logic set_pend;
    logic read_capture;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] req_type;
    logic       is_newline;
    logic       pending;
    logic       col_zero;
    logic       scroll_need;
    logic       at_text_end;
    logic       at_store_end;
  } dp_stat_t;

endpackage

// ----- hw/rtl/tcw_ram.sv -----
// ============================================================================
// Generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/tcw_dp.sv -----
// ============================================================================
// Text console character writer: datapath
// Cursor, color and request registers, sweep counter, screen store and the
// output register.
// ============================================================================
module tcw_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcw_pkg::in_item_t    in_data,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  tcw_pkg::ctrl_cmd_t   cmd,
  output tcw_pkg::dp_stat_t    stat,
  output tcw_pkg::out_item_t   out_data
);

  tcw_pkg::in_item_t             req_r;
  tcw_pkg::out_item_t            out_r;
  logic [4:0]                    row_r, row_nxt;
  logic [6:0]                    col_r, col_nxt;
  logic                          pend_r, pend_nxt;
  logic [7:0]                    color_r;
  logic [tcw_pkg::ADDR_W-1:0]    sweep_r, sweep_nxt;
  logic                          copy_wr_r;
  logic [tcw_pkg::ADDR_W-1:0]    copy_dst_r;
  logic [15:0]                   cell_r;

  logic                          rd_in_range;
  logic [tcw_pkg::ADDR_W-1:0]    read_addr;
  logic [tcw_pkg::ADDR_W-1:0]    cur_addr;
  logic [tcw_pkg::ADDR_W-1:0]    ram_rd_addr;
  logic [tcw_pkg::ADDR_W-1:0]    ram_wr_addr;
  logic [15:0]                   ram_wr_data;
  logic                          ram_wr_en;
  logic [15:0]                   ram_rd_data;
  logic [7:0]                    fill_color;

  assign rd_in_range = (int'(req_r.read_row) < tcw_pkg::ROWS) &&
                       (int'(req_r.read_col) < tcw_pkg::COLUMNS);
  assign read_addr   = rd_in_range ?
                       tcw_pkg::ADDR_W'(int'(req_r.read_row) * tcw_pkg::COLUMNS +
                                        int'(req_r.read_col)) : '0;
  assign cur_addr    = tcw_pkg::ADDR_W'(int'(row_r) * tcw_pkg::COLUMNS + int'(col_r));
  assign ram_rd_addr = cmd.copy_step ? sweep_r : read_addr;
  assign fill_color  = cmd.fill_init ? tcw_pkg::COLOR_RESET : color_r;

  // The pending copy write owns the port; the controller keeps fills and
  // character writes away from it.
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = cur_addr;
    ram_wr_data = {color_r, req_r.char_code};
    priority if (copy_wr_r) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = copy_dst_r;
      ram_wr_data = ram_rd_data;
    end else if (cmd.fill_step) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = sweep_r;
      ram_wr_data = {fill_color, tcw_pkg::CHAR_SPACE};
    end else begin
      ram_wr_en   = cmd.char_write;
    end
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (tcw_pkg::CELLS)
  ) u_screen (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    sweep_nxt = sweep_r;
    priority if (cmd.sweep_clr) begin
      sweep_nxt = '0;
    end else if (cmd.sweep_copy) begin
      sweep_nxt = tcw_pkg::COPY_FIRST;
    end else if (cmd.sweep_row) begin
      sweep_nxt = tcw_pkg::ROWFILL_FIRST;
    end else if (cmd.copy_step || cmd.fill_step) begin
      sweep_nxt = sweep_r + 1'b1;
    end else begin
      sweep_nxt = sweep_r;
    end
  end

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    pend_nxt = pend_r;
    if (cmd.line_adv) begin
      row_nxt  = (row_r >= tcw_pkg::ROW_TEXT_LAST) ? tcw_pkg::ROW_TEXT_LAST : row_r + 1'b1;
      col_nxt  = '0;
      pend_nxt = 1'b0;
    end
    if (cmd.cursor_home) begin
      row_nxt  = '0;
      col_nxt  = '0;
      pend_nxt = 1'b0;
    end
    if (cmd.char_write) begin
      if (col_r == tcw_pkg::COL_LAST) begin
        col_nxt  = '0;
        pend_nxt = 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (cmd.set_pend) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      pend_r    <= 1'b0;
      color_r   <= tcw_pkg::COLOR_RESET;
      sweep_r   <= '0;
      copy_wr_r <= 1'b0;
    end else begin
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      pend_r    <= pend_nxt;
      sweep_r   <= sweep_nxt;
      copy_wr_r <= cmd.copy_step;
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    copy_dst_r <= sweep_r - tcw_pkg::COLUMNS_A;
    if (cmd.load_req) begin
      req_r  <= in_data;
      cell_r <= '0;
    end else if (cmd.read_capture) begin
      cell_r <= rd_in_range ? ram_rd_data : '0;
    end
    if (cmd.out_load) begin
      out_r.cursor_row    <= row_r;
      out_r.cursor_col    <= col_r;
      out_r.break_pending <= pend_r;
      out_r.cell_data     <= cell_r;
    end
  end

  assign out_data = out_r;

  assign stat.req_type     = req_r.req_type;
  assign stat.is_newline   = (req_r.char_code == tcw_pkg::CHAR_NEWLINE);
  assign stat.pending      = pend_r;
  assign stat.col_zero     = (col_r == '0);
  assign stat.scroll_need  = (row_r >= tcw_pkg::ROW_TEXT_LAST);
  assign stat.at_text_end  = (sweep_r == tcw_pkg::TEXT_LAST);
  assign stat.at_store_end = (sweep_r == tcw_pkg::STORE_LAST);

endmodule

// ----- hw/rtl/tcw_ctrl.sv -----
// ============================================================================
// Text console character writer: controller
// Sequences each request through the datapath and owns both handshakes.
// ============================================================================
module tcw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  tcw_pkg::dp_stat_t    stat,
  output tcw_pkg::ctrl_cmd_t   cmd
);

  tcw_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            wr_char_r, wr_char_nxt;
  logic            act;

  assign act = !((stat.req_type == tcw_pkg::REQ_SOFT) && stat.col_zero);

  always_comb begin
    state_nxt   = state_r;
    wr_char_nxt = wr_char_r;
    cmd         = '0;
    unique case (state_r)
      tcw_pkg::ST_INIT: begin
        cmd.fill_step = 1'b1;
        cmd.fill_init = 1'b1;
        if (stat.at_store_end) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = tcw_pkg::ST_DISPATCH;
        end
      end
      tcw_pkg::ST_DISPATCH: begin
        unique case (stat.req_type)
          tcw_pkg::REQ_CLEAR: begin
            cmd.sweep_clr = 1'b1;
            state_nxt     = tcw_pkg::ST_CLEAR;
          end
          tcw_pkg::REQ_READ: begin
            state_nxt = tcw_pkg::ST_READ;
          end
          tcw_pkg::REQ_PUT, tcw_pkg::REQ_BREAK, tcw_pkg::REQ_SOFT: begin
            wr_char_nxt = (stat.req_type == tcw_pkg::REQ_PUT) && !stat.is_newline;
            if (!act) begin
              state_nxt = tcw_pkg::ST_DONE;
            end else if (stat.pending && stat.scroll_need) begin
              cmd.sweep_copy = 1'b1;
              state_nxt      = tcw_pkg::ST_COPY;
            end else begin
              cmd.line_adv = stat.pending;
              state_nxt    = tcw_pkg::ST_POST;
            end
          end
          default: begin
            state_nxt = tcw_pkg::ST_DONE;
          end
        endcase
      end
      tcw_pkg::ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (stat.at_text_end) begin
          state_nxt = tcw_pkg::ST_DRAIN;
        end
      end
      tcw_pkg::ST_DRAIN: begin
        cmd.sweep_row = 1'b1;
        state_nxt     = tcw_pkg::ST_ROWFILL;
      end
      tcw_pkg::ST_ROWFILL: begin
        cmd.fill_step = 1'b1;
        if (stat.at_text_end) begin
          cmd.line_adv = 1'b1;
          state_nxt    = tcw_pkg::ST_POST;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        cmd.fill_step = 1'b1;
        if (stat.at_store_end) begin
          cmd.cursor_home = 1'b1;
          state_nxt       = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_READ: begin
        cmd.read_capture = 1'b1;
        state_nxt        = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_POST: begin
        cmd.char_write = wr_char_r;
        cmd.set_pend   = !wr_char_r;
        state_nxt      = tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_INIT;
      out_valid_r <= 1'b0;
      wr_char_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wr_char_r   <= wr_char_nxt;
    end
  end

  assign in_stall  = (state_r != tcw_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/text_console_char_writer_core.sv -----
// ============================================================================
// Text console character writer core
// Text-mode console over a screen store of 16-bit cells with deferred line
// breaks, scrolling of the text rows and single-cell read-back.
// ============================================================================
//
//   Channel  Direction  Beat / write           Handshake
//   -------  ---------  ---------------------  ------------------------------
//   in_      input      in_item_t request      in_valid / in_stall
//   out_     output     out_item_t result      out_valid / out_stall
//   cfg_     input      8-bit text color       cfg_wr_en, no wait
//
// A put character, break, soft break or read passes through dispatch, a
// middle phase (post or read) and done, where the result register loads.
// A soft break at column zero and an unused command skip the middle
// phase. A break that scrolls adds a copy of the text rows up by one
// row and a fill of the freed row, and a clear walks the whole store;
// both are paced by the single write port of the screen store.
// After reset the store is swept to spaces in color 7 while in_stall
// stays high; color writes are taken during that sweep.
// A stalled result sits in the output register and the next beat is still
// accepted; only the finish of that next request waits for the register.
// ============================================================================
module text_console_char_writer_core (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  tcw_pkg::in_item_t   in_data,

  output logic                out_valid,
  input  logic                out_stall,
  output tcw_pkg::out_item_t  out_data,

  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);

  // Commands and status between the sequencer and the datapath.
  tcw_pkg::ctrl_cmd_t cmd;
  tcw_pkg::dp_stat_t  stat;

  // The controller walks each request through its phases: dispatch, then for a
  // character or break an optional scroll (copy, drain, fill of the freed row) and the final
  // character write or pending-break update, a sweep for a clear or a capture for a read, and finally the result load.
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the cursor, the color register, the sweep counter
  // and the screen store, and registers the result beat.
  tcw_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (out_data)
  );

  // The cursor never lands on the reserved bottom row or past the last column.
  a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_data.cursor_row) <= tcw_pkg::ROWS - 2) &&
                  (int'(out_data.cursor_col) < tcw_pkg::COLUMNS))
    else $error("cursor outside the text area");

  // Only one source may claim the store write port in a cycle.
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.copy_step, cmd.fill_step, cmd.char_write}))
    else $error("conflicting screen store writes");

  // Requests other than a cell read return zero cell data.
  a_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && (stat.req_type != tcw_pkg::REQ_READ)) |=> (out_data.cell_data == '0))
    else $error("cell data on a non-read result");

  // A result is loaded only once the previous one has been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !cmd.out_load)
    else $error("result register overwritten while stalled");

endmodule

// ----- tb/tb_text_console_char_writer_core.sv -----
// ============================================================================
// Text console character writer core: self-checking testbench
// A short directed table walks reset contents, out-of-range reads, deferred
// breaks, newline, line wrap, scrolling and clear. Random text streams follow
// under several text colors and idling patterns. Every result beat is checked
// against a cycle-free model of the console kept inside this bench or a fixed status.
// ============================================================================
module tb_text_console_char_writer_core;

  // Command codes the block must ignore.
  localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

  localparam int PLAN_LEN   = 25;
  localparam int SEG_COUNT  = 6;
  localparam int SEG_ITEMS  = 275;
  localparam int TAIL_CYCLES = 64;
  // A scroll walks the text area and a clear the whole store. Even if every one of the
  // roughly 1800 beats scrolled and waited out long receiver stalls, the run
  // would stay well below this bound, which also covers the power-up sweep.
  localparam int CYCLE_LIMIT = 40_000_000;

  // One beat waiting to be driven, with an optional fixed status that
  // overrides the model's prediction.
  typedef struct {
    tcw_pkg::in_item_t  req;
    bit                 pinned;
    tcw_pkg::out_item_t want;
  } console_beat_t;

  // One row of the directed table; reps repeats the same request.
  typedef struct {
    tcw_pkg::in_item_t  req;
    int                 reps;
    bit                 pinned;
    tcw_pkg::out_item_t want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  tcw_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  tcw_pkg::out_item_t out_data;
  logic               cfg_wr_en;
  logic [7:0]         cfg_wr_data;

  // Console model state.
  logic [15:0] screen [tcw_pkg::CELLS];
  int          cur_row;
  int          cur_col;
  bit          brk_pend;
  logic [7:0]  txt_color;

  // Bench bookkeeping.
  console_beat_t      req_backlog[$];
  console_beat_t      live_beat;
  tcw_pkg::out_item_t due_status_q[$];
  bit                 took_last;
  int                 beats_queued;
  int                 beats_taken;
  int                 mismatch_count;
  int                 gap_pct;
  int                 stall_pct;

  plan_row_t plan [PLAN_LEN];

  text_console_char_writer_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Console model
  // --------------------------------------------------------------------------

  task automatic console_reset();
    for (int i = 0; i < tcw_pkg::CELLS; i++) begin
      screen[i] = {tcw_pkg::COLOR_RESET, tcw_pkg::CHAR_SPACE};
    end
    cur_row   = 0;
    cur_col   = 0;
    brk_pend  = 1'b0;
    txt_color = tcw_pkg::COLOR_RESET;
  endtask

  // Move to the next text row. Reaching the reserved bottom row instead
  // shifts the text rows up by one and blanks the last text row.
  task automatic start_line();
    cur_row++;
    if (cur_row >= tcw_pkg::ROWS - 1) begin
      cur_row = tcw_pkg::ROWS - 2;
      for (int i = 0; i < (tcw_pkg::ROWS - 2) * tcw_pkg::COLUMNS; i++) begin
        screen[i] = screen[i + tcw_pkg::COLUMNS];
      end
      for (int i = 0; i < tcw_pkg::COLUMNS; i++) begin
        screen[cur_row * tcw_pkg::COLUMNS + i] = {txt_color, tcw_pkg::CHAR_SPACE};
      end
    end
    cur_col  = 0;
    brk_pend = 1'b0;
  endtask

  // A break only defers; an earlier deferred break is carried out first.
  task automatic queue_break();
    if (brk_pend) start_line();
    brk_pend = 1'b1;
  endtask

  task automatic console_apply(input tcw_pkg::in_item_t r,
                               output tcw_pkg::out_item_t s);
    logic [15:0] rd_word;
    rd_word = '0;
    case (r.req_type)
      tcw_pkg::REQ_PUT: begin
        if (brk_pend) start_line();
        if (r.char_code == tcw_pkg::CHAR_NEWLINE) begin
          queue_break();
        end else begin
          screen[cur_row * tcw_pkg::COLUMNS + cur_col] = {txt_color, r.char_code};
          cur_col++;
          if (cur_col >= tcw_pkg::COLUMNS) begin
            cur_col = 0;
            queue_break();
          end
        end
      end
      tcw_pkg::REQ_BREAK: queue_break();
      tcw_pkg::REQ_SOFT: begin
        if (cur_col > 0) queue_break();
      end
      tcw_pkg::REQ_CLEAR: begin
        for (int i = 0; i < tcw_pkg::CELLS; i++) begin
          screen[i] = {txt_color, tcw_pkg::CHAR_SPACE};
        end
        cur_row  = 0;
        cur_col  = 0;
        brk_pend = 1'b0;
      end
      tcw_pkg::REQ_READ: begin
        if (int'(r.read_row) < tcw_pkg::ROWS && int'(r.read_col) < tcw_pkg::COLUMNS)
          rd_word = screen[int'(r.read_row) * tcw_pkg::COLUMNS + int'(r.read_col)];
      end
      default: ;
    endcase
    s.cursor_row    = 5'(cur_row);
    s.cursor_col    = 7'(cur_col);
    s.break_pending = brk_pend;
    s.cell_data     = rd_word;
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Rising edge: config shadow, accepted requests and result checking.
  // All DUT outputs are read here before the DUT's own updates land.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : sample_edge
    tcw_pkg::out_item_t predicted;
    tcw_pkg::out_item_t want;
    took_last = 1'b0;
    if (!rst_n) begin
      console_reset();
    end else begin
      if (cfg_wr_en) txt_color = cfg_wr_data;

      // A request beat goes through the model at the edge it is taken, so the
      // model order matches the order the block sees.
      if (in_valid && in_stall === 1'b0) begin
        took_last = 1'b1;
        console_apply(live_beat.req, predicted);
        due_status_q.push_back(live_beat.pinned ? live_beat.want : predicted);
        beats_taken++;
      end

      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        if (due_status_q.size() == 0) begin
          flag_mismatch("result beat with nothing outstanding", 32'(out_data), '0);
        end else begin
          want = due_status_q.pop_front();
          if (out_data.cursor_row !== want.cursor_row)
            flag_mismatch("cursor_row", 32'(out_data.cursor_row), 32'(want.cursor_row));
          if (out_data.cursor_col !== want.cursor_col)
            flag_mismatch("cursor_col", 32'(out_data.cursor_col), 32'(want.cursor_col));
          if (out_data.break_pending !== want.break_pending)
            flag_mismatch("break_pending", 32'(out_data.break_pending),
                          32'(want.break_pending));
          if (out_data.cell_data !== want.cell_data)
            flag_mismatch("cell_data", 32'(out_data.cell_data), 32'(want.cell_data));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Falling edge: request driver and receiver stall.
  // A presented request holds until it is taken; whether a new one is offered
  // depends only on the backlog and the gap dice, never on in_stall.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (!in_valid || took_last) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
        live_beat = req_backlog.pop_front();
        in_valid <= 1'b1;
        in_data  <= live_beat.req;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Returns on a falling edge once every queued beat has been taken and
  // answered. Every request yields exactly one result, so the block is idle.
  task automatic wait_idle();
    do @(negedge clk);
    while (beats_taken != beats_queued || due_status_q.size() != 0);
  endtask

  // Called on a falling edge; the model picks the color up at the next
  // rising edge together with the block.
  task automatic set_text_color(input logic [7:0] color);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= color;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("text_console_char_writer_core test failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    console_beat_t nxt;
    int            pick;
    int            counted;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    took_last      = 1'b0;
    beats_queued   = 0;
    beats_taken    = 0;
    mismatch_count = 0;
    gap_pct        = 35;
    stall_pct      = 59;

    // Directed table. Fixed statuses are used where they follow directly
    // from reset contents, the color-7 default or a single step of the
    // cursor; longer runs rely on the model.
    plan = '{
      // Power-up contents, reserved row, and reads off the screen.
      '{'{tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd0}, 1, 1'b1,
        '{5'd0, 7'd0, 1'b0, {tcw_pkg::COLOR_RESET, tcw_pkg::CHAR_SPACE}}},
      '{'{tcw_pkg::REQ_READ, 8'h00, 5'd24, 7'd79}, 1, 1'b1,
        '{5'd0, 7'd0, 1'b0, {tcw_pkg::COLOR_RESET, tcw_pkg::CHAR_SPACE}}},
      '{'{tcw_pkg::REQ_READ, 8'h00, 5'd25, 7'd0}, 1, 1'b1,
        '{5'd0, 7'd0, 1'b0, 16'h0000}},
      '{'{tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd80}, 1, 1'b1,
        '{5'd0, 7'd0, 1'b0, 16'h0000}},
      '{'{tcw_pkg::REQ_READ, 8'hFF, 5'd31, 7'd127}, 1, 1'b1,
        '{5'd0, 7'd0, 1'b0, 16'h0000}},
      // Soft break at column zero does nothing.
      '{'{tcw_pkg::REQ_SOFT, 8'h00, 5'd0, 7'd0}, 1, 1'b1,
        '{5'd0, 7'd0, 1'b0, 16'h0000}},
      '{'{tcw_pkg::REQ_PUT, 8'h41, 5'd0, 7'd0}, 1, 1'b1,
        '{5'd0, 7'd1, 1'b0, 16'h0000}},
      '{'{tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd0}, 1, 1'b1,
        '{5'd0, 7'd1, 1'b0, {tcw_pkg::COLOR_RESET, 8'h41}}},
      '{'{tcw_pkg::REQ_PUT, 8'h00, 5'd0, 7'd0}, 1, 1'b0,
        '{5'd0, 7'd0, 1'b0, 16'h0000}},
      '{'{tcw_pkg::REQ_PUT, 8'hFF, 5'd31, 7'd127}, 1, 1'b0,
        '{5'd0, 7'd0, 1'b0, 16'h0000}},
      // Soft break mid-line defers, a second break starts the line and
      // defers again, a newline behaves as a break.
      '{'{tcw_pkg::REQ_SOFT, 8'h00, 5'd0, 7'd0}, 1, 1'b1,
        '{5'd0, 7'd3, 1'b1, 16'h0000}},
      '{'{tcw_pkg::REQ_BREAK, 8'h00, 5'd0, 7'd0}, 1, 1'b1,
        '{5'd1, 7'd0, 1'b1, 16'h0000}},
      '{'{tcw_pkg::REQ_PUT, tcw_pkg::CHAR_NEWLINE, 5'd0, 7'd0}, 1, 1'b1,
        '{5'd2, 7'd0, 1'b1, 16'h0000}},
      '{'{tcw_pkg::REQ_PUT, 8'h42, 5'd0, 7'd0}, 1, 1'b1,
        '{5'd3, 7'd1, 1'b0, 16'h0000}},
      // Unused command codes leave everything alone.
      '{'{REQ_UNUSED_FIRST, 8'h00, 5'd0, 7'd0}, 1, 1'b1,
        '{5'd3, 7'd1, 1'b0, 16'h0000}},
      '{'{REQ_UNUSED_LAST, 8'hFF, 5'd31, 7'd127}, 1, 1'b1,
        '{5'd3, 7'd1, 1'b0, 16'h0000}},
      '{'{tcw_pkg::REQ_CLEAR, 8'h00, 5'd0, 7'd0}, 1, 1'b1,
        '{5'd0, 7'd0, 1'b0, 16'h0000}},
      '{'{tcw_pkg::REQ_READ, 8'h00, 5'd3, 7'd0}, 1, 1'b1,
        '{5'd0, 7'd0, 1'b0, {tcw_pkg::COLOR_RESET, tcw_pkg::CHAR_SPACE}}},
      // Fill a whole line so the wrap defers a break.
      '{'{tcw_pkg::REQ_PUT, 8'h5A, 5'd0, 7'd0}, tcw_pkg::COLUMNS, 1'b0,
        '{5'd0, 7'd0, 1'b0, 16'h0000}},
      '{'{tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd79}, 1, 1'b0,
        '{5'd0, 7'd0, 1'b0, 16'h0000}},
      // Enough breaks to run into the bottom and scroll repeatedly.
      '{'{tcw_pkg::REQ_BREAK, 8'h00, 5'd0, 7'd0}, 30, 1'b0,
        '{5'd0, 7'd0, 1'b0, 16'h0000}},
      '{'{tcw_pkg::REQ_PUT, 8'h7E, 5'd0, 7'd0}, 3, 1'b0,
        '{5'd0, 7'd0, 1'b0, 16'h0000}},
      '{'{tcw_pkg::REQ_READ, 8'h00, 5'd23, 7'd0}, 1, 1'b0,
        '{5'd0, 7'd0, 1'b0, 16'h0000}},
      '{'{tcw_pkg::REQ_READ, 8'h00, 5'd22, 7'd1}, 1, 1'b0,
        '{5'd0, 7'd0, 1'b0, 16'h0000}},
      '{'{tcw_pkg::REQ_READ, 8'h00, 5'd24, 7'd0}, 1, 1'b0,
        '{5'd0, 7'd0, 1'b0, 16'h0000}}
    };

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // The block holds in_stall high through its power-up sweep; the driver
    // simply waits on the handshake.
    @(posedge clk);
    foreach (plan[p]) begin
      for (int k = 0; k < plan[p].reps; k++) begin
        nxt.req    = plan[p].req;
        nxt.pinned = plan[p].pinned;
        nxt.want   = plan[p].want;
        req_backlog.push_back(nxt);
        beats_queued++;
      end
    end

    // Random text streams. Each segment starts from an idle block with a new
    // text color; the extremes come first. Two segments per idling pattern.
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      wait_idle();
      set_text_color(seg == 0 ? 8'h00 : (seg == 1 ? 8'hFF : 8'($urandom_range(255))));
      @(posedge clk);
      case (seg / 2)
        0: begin
          gap_pct   = 35;
          stall_pct = 59;
        end
        1: begin
          gap_pct   = 59;
          stall_pct = 35;
        end
        default: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
      endcase

      counted = 0;
      while (counted < SEG_ITEMS) begin
        nxt.pinned = 1'b0;
        nxt.want   = '0;
        // Mostly characters, so lines fill and wrap; breaks are kept rare
        // because each scroll walks the whole text area.
        nxt.req.char_code = ($urandom_range(29) == 0) ? tcw_pkg::CHAR_NEWLINE :
                                                        8'($urandom);
        if ($urandom_range(6) == 0) begin
          nxt.req.read_row = 5'($urandom);
          nxt.req.read_col = 7'($urandom);
        end else begin
          nxt.req.read_row = 5'($urandom_range(tcw_pkg::ROWS - 1));
          nxt.req.read_col = 7'($urandom_range(tcw_pkg::COLUMNS - 1));
        end
        pick = $urandom_range(999);
        if (pick < 700)      nxt.req.req_type = tcw_pkg::REQ_PUT;
        else if (pick < 760) nxt.req.req_type = tcw_pkg::REQ_BREAK;
        else if (pick < 830) nxt.req.req_type = tcw_pkg::REQ_SOFT;
        else if (pick < 840) nxt.req.req_type = tcw_pkg::REQ_CLEAR;
        else if (pick < 980) nxt.req.req_type = tcw_pkg::REQ_READ;
        else nxt.req.req_type = 3'($urandom_range(int'(REQ_UNUSED_LAST),
                                                  int'(REQ_UNUSED_FIRST)));
        req_backlog.push_back(nxt);
        beats_queued++;
        // Ignored codes ride along but do not count toward the segment.
        if (nxt.req.req_type < REQ_UNUSED_FIRST) counted++;
      end
    end

    wait_idle();
    // Any stray result beat after this point is caught by the checker.
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("text_console_char_writer_core test passed");
    end else begin
      $display("text_console_char_writer_core test failed");
    end
    $finish;
  end

endmodule
